// ===== src/tafu_pkg.sv =====
// shared types, opcodes and widths for the thumb alu
`default_nettype none
package tafu_pkg;

	localparam int DW = 32;
	localparam int SHAMT_W = 8;
	localparam int NBYTES = DW / 8;
	localparam int NHALF = DW / 16;

	typedef enum logic [4:0] {
		MODE_ADD   = 5'd0,
		MODE_ADC   = 5'd1,
		MODE_SUB   = 5'd2,
		MODE_SBC   = 5'd3,
		MODE_NEG   = 5'd4,
		MODE_AND   = 5'd5,
		MODE_EOR   = 5'd6,
		MODE_ORR   = 5'd7,
		MODE_BIC   = 5'd8,
		MODE_MOV   = 5'd9,
		MODE_MVN   = 5'd10,
		MODE_MUL   = 5'd11,
		MODE_LSL   = 5'd12,
		MODE_LSR   = 5'd13,
		MODE_ASR   = 5'd14,
		MODE_ROR   = 5'd15,
		MODE_REV   = 5'd16,
		MODE_REV16 = 5'd17,
		MODE_REVSH = 5'd18,
		MODE_CMN   = 5'd19,
		MODE_CMP   = 5'd20,
		MODE_TST   = 5'd21
	} mode_t;

	typedef struct packed {
		logic [4:0]    mode;
		logic [DW-1:0] op_a;
		logic [DW-1:0] op_b;
		logic          carry_in;
		logic          overflow_in;
	} alu_in_t;

	typedef struct packed {
		logic [DW-1:0] result;
		logic          writes_result;
		logic          sets_flags;
		logic          flag_n;
		logic          flag_z;
		logic          flag_c;
		logic          flag_v;
	} alu_out_t;

	typedef struct packed {
		logic [DW-1:0] value;
		logic          carry;
	} shift_res_t;

endpackage
`default_nettype wire

// ===== src/tafu_in_if.sv =====
// operation channel: valid/ready plus opcode, operands and incoming flags
`default_nettype none
interface tafu_in_if
	import tafu_pkg::*;
;
	logic          valid;
	logic          ready;
	logic [4:0]    mode;
	logic [DW-1:0] op_a;
	logic [DW-1:0] op_b;
	logic          carry_in;
	logic          overflow_in;

	modport source (output valid, mode, op_a, op_b, carry_in, overflow_in, input ready);
	modport sink (input valid, mode, op_a, op_b, carry_in, overflow_in, output ready);
endinterface
`default_nettype wire

// ===== src/tafu_out_if.sv =====
// result channel: valid/ready plus result value and nzcv flags
`default_nettype none
interface tafu_out_if
	import tafu_pkg::*;
;
	logic          valid;
	logic          ready;
	logic [DW-1:0] result;
	logic          writes_result;
	logic          sets_flags;
	logic          flag_n;
	logic          flag_z;
	logic          flag_c;
	logic          flag_v;

	modport source (output valid, result, writes_result, sets_flags, flag_n, flag_z, flag_c,
		flag_v, input ready);
	modport sink (input valid, result, writes_result, sets_flags, flag_n, flag_z, flag_c,
		flag_v, output ready);
endinterface
`default_nettype wire

// ===== src/tafu_shift.sv =====
// barrel shifter for lsl, lsr, asr and ror with shifter carry out
`default_nettype none
module tafu_shift
	import tafu_pkg::*;
(
	input  wire logic [4:0]         mode,
	input  wire logic [DW-1:0]      op_a,
	input  wire logic [SHAMT_W-1:0] amount,
	input  wire logic               carry_in,
	output shift_res_t              res
);

	logic [DW:0]     lsl_full;
	logic [DW:0]     lsr_full;
	logic [DW:0]     asr_full;
	logic [2*DW-1:0] ror_full;
	logic [DW-1:0]   ror_val;

	always_comb begin
		lsl_full = {1'b0, op_a} << amount;
		lsr_full = {op_a, 1'b0} >> amount;
		asr_full = $signed({op_a, 1'b0}) >>> amount;
		ror_full = {op_a, op_a} >> amount[$clog2(DW)-1:0];
		ror_val = ror_full[DW-1:0];

		res.value = op_a;
		res.carry = carry_in;
		case (mode)
			MODE_LSL: begin
				res.value = lsl_full[DW-1:0];
				if (amount != '0) res.carry = lsl_full[DW];
			end
			MODE_LSR: begin
				res.value = lsr_full[DW:1];
				if (amount != '0) res.carry = lsr_full[0];
			end
			MODE_ASR: begin
				res.value = asr_full[DW:1];
				if (amount != '0) res.carry = asr_full[0];
			end
			MODE_ROR: begin
				res.value = ror_val;
				if (amount != '0) res.carry = ror_val[DW-1];
			end
			default: begin
				res.value = op_a;
				res.carry = carry_in;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/tafu_alu.sv =====
// combinational datapath: adder, logic, multiply, shifts, byte reversal, flags
`default_nettype none
module tafu_alu
	import tafu_pkg::*;
(
	input  alu_in_t  op,
	output alu_out_t res
);

	logic [DW-1:0]   add_x;
	logic [DW-1:0]   add_y;
	logic            add_cin;
	logic [DW:0]     sum;
	logic            add_v;
	logic [2*DW-1:0] prod;
	logic [DW-1:0]   rev_val;
	logic [DW-1:0]   rev16_val;
	logic [DW-1:0]   val;
	logic            use_adder;
	logic            known;
	shift_res_t      sh;

	tafu_shift u_shift (
		.mode     (op.mode),
		.op_a     (op.op_a),
		.amount   (op.op_b[SHAMT_W-1:0]),
		.carry_in (op.carry_in),
		.res      (sh)
	);

	// adder operand select
	always_comb begin
		add_x = op.op_a;
		add_y = op.op_b;
		add_cin = 1'b0;
		use_adder = 1'b1;
		case (op.mode)
			MODE_ADD, MODE_CMN: begin
				add_y = op.op_b;
				add_cin = 1'b0;
			end
			MODE_ADC: add_cin = op.carry_in;
			MODE_SUB, MODE_CMP: begin
				add_y = ~op.op_b;
				add_cin = 1'b1;
			end
			MODE_SBC: begin
				add_y = ~op.op_b;
				add_cin = op.carry_in;
			end
			MODE_NEG: begin
				add_x = '0;
				add_y = ~op.op_a;
				add_cin = 1'b1;
			end
			default: use_adder = 1'b0;
		endcase
		sum = {1'b0, add_x} + {1'b0, add_y} + {{DW{1'b0}}, add_cin};
		add_v = (add_x[DW-1] == add_y[DW-1]) && (sum[DW-1] != add_x[DW-1]);
	end

	always_comb begin
		prod = op.op_a * op.op_b;
		for (int i = 0; i < NBYTES; i++) begin
			rev_val[8*i +: 8] = op.op_a[8*(NBYTES-1-i) +: 8];
		end
		for (int h = 0; h < NHALF; h++) begin
			rev16_val[16*h +: 16] = {op.op_a[16*h +: 8], op.op_a[16*h+8 +: 8]};
		end
	end

	always_comb begin
		val = '0;
		known = 1'b1;
		res.writes_result = 1'b1;
		res.sets_flags = 1'b0;
		res.flag_c = op.carry_in;
		res.flag_v = op.overflow_in;
		case (op.mode)
			MODE_ADD, MODE_ADC, MODE_SUB, MODE_SBC, MODE_NEG: val = sum[DW-1:0];
			MODE_AND:   val = op.op_a & op.op_b;
			MODE_EOR:   val = op.op_a ^ op.op_b;
			MODE_ORR:   val = op.op_a | op.op_b;
			MODE_BIC:   val = op.op_a & ~op.op_b;
			MODE_MOV:   val = op.op_a;
			MODE_MVN:   val = ~op.op_a;
			MODE_MUL:   val = prod[DW-1:0];
			MODE_LSL, MODE_LSR, MODE_ASR, MODE_ROR: begin
				val = sh.value;
				res.flag_c = sh.carry;
			end
			MODE_REV:   val = rev_val;
			MODE_REV16: val = rev16_val;
			MODE_REVSH: val = {{(DW-16){op.op_a[7]}}, op.op_a[7:0], op.op_a[15:8]};
			MODE_CMN, MODE_CMP: begin
				val = sum[DW-1:0];
				res.writes_result = 1'b0;
				res.sets_flags = 1'b1;
			end
			MODE_TST: begin
				val = op.op_a & op.op_b;
				res.writes_result = 1'b0;
				res.sets_flags = 1'b1;
			end
			default: begin
				known = 1'b0;
				res.writes_result = 1'b0;
			end
		endcase
		if (use_adder) begin
			res.flag_c = sum[DW];
			res.flag_v = add_v;
		end
		res.result = res.writes_result ? val : '0;
		res.flag_n = known & val[DW-1];
		res.flag_z = known & (val == '0);
	end

endmodule
`default_nettype wire

// ===== src/thumb_alu_with_flags_unit.sv =====
// top level: input register, alu datapath, result register
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------
//  alu_in   | in  | mode, op_a, op_b, carry_in, overflow_in
//  alu_out  | out | result, writes_result, sets_flags, flag_n/z/c/v
//
// two register stages: an accepted beat is held in op_s1, then its alu result is registered in res_s2 for alu_out.
// one beat per cycle sustained while alu_out is ready; the 32x32 multiply sets the path between the registers.
// arst_n clears both stage valids; operand and result registers are not reset.
// a stall on alu_out holds stage two; alu_in stays ready while stage one is free
// or stage two can take its beat.
`default_nettype none
module thumb_alu_with_flags_unit
	import tafu_pkg::*;
(
	input wire logic  clk,
	input wire logic  arst_n,
	tafu_in_if.sink   alu_in,
	tafu_out_if.source alu_out
);

	logic     valid_s1;
	logic     valid_s2;
	alu_in_t  op_s1;
	alu_out_t res_s2;
	alu_out_t alu_res;
	logic     adv_s2;
	logic     ready_in;

	assign adv_s2 = !valid_s2 || alu_out.ready;
	assign ready_in = !valid_s1 || adv_s2;
	assign alu_in.ready = ready_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_in) valid_s1 <= alu_in.valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_in && alu_in.valid) begin
			op_s1 <= '{mode: alu_in.mode, op_a: alu_in.op_a, op_b: alu_in.op_b,
				carry_in: alu_in.carry_in, overflow_in: alu_in.overflow_in};
		end
		if (adv_s2 && valid_s1) res_s2 <= alu_res;
	end

	tafu_alu u_alu (
		.op  (op_s1),
		.res (alu_res)
	);

	assign alu_out.valid = valid_s2;
	assign alu_out.result = res_s2.result;
	assign alu_out.writes_result = res_s2.writes_result;
	assign alu_out.sets_flags = res_s2.sets_flags;
	assign alu_out.flag_n = res_s2.flag_n;
	assign alu_out.flag_z = res_s2.flag_z;
	assign alu_out.flag_c = res_s2.flag_c;
	assign alu_out.flag_v = res_s2.flag_v;

endmodule
`default_nettype wire
